[hdl/i2cm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types, phase codes and command codes for the byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam int DELAY_BITS = 16;
   localparam int CSR_BITS   = 16;

   localparam logic [CSR_BITS-1:0]   DELAY_RESET   = CSR_BITS'(1);
   localparam logic [DELAY_BITS-1:0] WAIT_ONE      = DELAY_BITS'(1);
   localparam logic [3:0]            BITS_PER_BYTE = 4'd8;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   typedef enum logic [11:0] {
      PH_IDLE     = 12'h001,
      PH_PRE      = 12'h002,
      PH_SLOT     = 12'h004,
      PH_SDA_WAIT = 12'h008,
      PH_DLY_A    = 12'h010,
      PH_SCL_REL  = 12'h020,
      PH_SCL_WAIT = 12'h040,
      PH_DLY_B    = 12'h080,
      PH_SAMPLE   = 12'h100,
      PH_DLY_C    = 12'h200,
      PH_SDA_LOW  = 12'h400,
      PH_DLY_D    = 12'h800
   } phase_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] write_byte;
      logic       send_nack;
      logic       sda_level;
      logic       scl_level;
   } item_type;

   typedef struct packed {
      logic       scl_pull_low;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_missing;
   } result_type;

   // Truncate or zero-extend the programmed delay to the counter width
   function automatic logic [DELAY_BITS-1:0] load_delay(input logic [CSR_BITS-1:0] ticks);
      return DELAY_BITS'(ticks);
   endfunction

endpackage
`default_nettype wire

[hdl/i2cm_in_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master input register
// Holds one accepted item until the engine takes it.
// ----------------------------------------------------------------------------
module i2cm_in_reg
   import i2cm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output      logic     req_ready,
   input  wire item_type req_item,
   input  wire logic     take,
   output      logic     item_valid,
   output      item_type item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req_ready  = !valid_ff || take;
   assign valid_in   = (req_valid && req_ready) || (valid_ff && !take);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   // Taking an item requires one to be held
   assert property (@(posedge clock) disable iff (reset) take |-> valid_ff)
      else $error("engine took an item from an empty input register");

endmodule
`default_nettype wire

[hdl/i2cm_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master byte engine core
// Phase sequencer: one step per item, bit shifting, ACK handling, delays.
// ----------------------------------------------------------------------------
module i2cm_core
   import i2cm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_en,
   input  wire logic [CSR_BITS-1:0] csr_write_data,
   input  wire logic                step,
   input  wire item_type            item,
   output      result_type          result
);

   logic [CSR_BITS-1:0]   delay_ff;
   phase_type             phase_ff, phase_in;
   logic                  is_read_ff, is_read_in;
   logic                  nack_ff, nack_in;
   logic [3:0]            bit_count_ff, bit_count_in;
   logic [7:0]            shift_ff, shift_in;
   logic [DELAY_BITS-1:0] wait_ff, wait_in;
   logic                  scl_drive_ff, scl_drive_in;
   logic                  sda_drive_ff, sda_drive_in;
   logic                  ack_flag_ff, ack_flag_in;
   logic [7:0]            read_hold_ff, read_hold_in;

   logic                  dly_done;
   logic [DELAY_BITS-1:0] wait_dec;
   logic                  data_bit;
   logic                  need_wait;
   logic                  finish;

   assign dly_done = (wait_ff <= WAIT_ONE);
   assign wait_dec = wait_ff - WAIT_ONE;
   assign data_bit = (bit_count_ff < BITS_PER_BYTE);

   always_comb begin
      phase_in     = phase_ff;
      is_read_in   = is_read_ff;
      nack_in      = nack_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      wait_in      = wait_ff;
      scl_drive_in = scl_drive_ff;
      sda_drive_in = sda_drive_ff;
      ack_flag_in  = ack_flag_ff;
      read_hold_in = read_hold_ff;
      need_wait    = 1'b0;
      finish       = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (item.cmd == CMD_WRITE || item.cmd == CMD_READ) begin
               is_read_in   = (item.cmd == CMD_READ);
               nack_in      = item.send_nack;
               bit_count_in = 4'd0;
               shift_in     = (item.cmd == CMD_READ) ? 8'h00 : item.write_byte;
               phase_in     = PH_PRE;
               wait_in      = load_delay(delay_ff);
            end
         end
         PH_PRE: begin
            if (dly_done) phase_in = PH_SLOT;
            else          wait_in  = wait_dec;
         end
         PH_SLOT: begin
            if (data_bit) begin
               if (is_read_ff) begin
                  sda_drive_in = 1'b0;
                  need_wait    = 1'b0;
               end else begin
                  sda_drive_in = !shift_ff[7];
                  need_wait    = shift_ff[7];
               end
            end else if (is_read_ff) begin
               sda_drive_in = !nack_ff;
               need_wait    = nack_ff;
            end else begin
               sda_drive_in = 1'b0;
               need_wait    = 1'b0;
            end
            // released SDA must be seen high before the clock pulse
            if (need_wait) begin
               phase_in = PH_SDA_WAIT;
            end else begin
               phase_in = PH_DLY_A;
               wait_in  = load_delay(delay_ff);
            end
         end
         PH_SDA_WAIT: begin
            if (item.sda_level) begin
               phase_in = PH_DLY_A;
               wait_in  = load_delay(delay_ff);
            end
         end
         PH_DLY_A: begin
            if (dly_done) phase_in = PH_SCL_REL;
            else          wait_in  = wait_dec;
         end
         PH_SCL_REL: begin
            scl_drive_in = 1'b0;
            phase_in     = PH_SCL_WAIT;
         end
         PH_SCL_WAIT: begin
            // hold here while a slave stretches the clock
            if (item.scl_level) begin
               phase_in = PH_DLY_B;
               wait_in  = load_delay(delay_ff);
            end
         end
         PH_DLY_B: begin
            if (dly_done) phase_in = PH_SAMPLE;
            else          wait_in  = wait_dec;
         end
         PH_SAMPLE: begin
            if (data_bit) begin
               if (is_read_ff) shift_in = {shift_ff[6:0], item.sda_level};
            end else if (!is_read_ff) begin
               ack_flag_in = item.sda_level;
            end
            scl_drive_in = 1'b1;
            phase_in     = PH_DLY_C;
            wait_in      = load_delay(delay_ff);
         end
         PH_DLY_C: begin
            if (dly_done) begin
               if (data_bit) begin
                  if (!is_read_ff) shift_in = {shift_ff[6:0], 1'b0};
                  bit_count_in = bit_count_ff + 4'd1;
                  phase_in     = PH_SLOT;
               end else if (is_read_ff && !nack_ff) begin
                  finish = 1'b1;
               end else begin
                  phase_in = PH_SDA_LOW;
               end
            end else begin
               wait_in = wait_dec;
            end
         end
         PH_SDA_LOW: begin
            sda_drive_in = 1'b1;
            phase_in     = PH_DLY_D;
            wait_in      = load_delay(delay_ff);
         end
         PH_DLY_D: begin
            if (dly_done) finish  = 1'b1;
            else          wait_in = wait_dec;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (finish) begin
         if (is_read_ff) read_hold_in = shift_ff;
         phase_in = PH_IDLE;
      end
   end

   assign result.scl_pull_low = scl_drive_in;
   assign result.sda_pull_low = sda_drive_in;
   assign result.busy_res     = (phase_in != PH_IDLE);
   assign result.done_res     = finish;
   assign result.read_byte    = read_hold_in;
   assign result.ack_missing  = ack_flag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= DELAY_RESET;
         phase_ff     <= PH_IDLE;
         is_read_ff   <= 1'b0;
         nack_ff      <= 1'b0;
         bit_count_ff <= 4'd0;
         shift_ff     <= 8'h00;
         wait_ff      <= '0;
         scl_drive_ff <= 1'b0;
         sda_drive_ff <= 1'b0;
         ack_flag_ff  <= 1'b0;
         read_hold_ff <= 8'h00;
      end else begin
         if (csr_write_en) delay_ff <= csr_write_data;
         if (step) begin
            phase_ff     <= phase_in;
            is_read_ff   <= is_read_in;
            nack_ff      <= nack_in;
            bit_count_ff <= bit_count_in;
            shift_ff     <= shift_in;
            wait_ff      <= wait_in;
            scl_drive_ff <= scl_drive_in;
            sda_drive_ff <= sda_drive_in;
            ack_flag_ff  <= ack_flag_in;
            read_hold_ff <= read_hold_in;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) bit_count_ff <= BITS_PER_BYTE)
      else $error("bit counter ran past one byte");

   assert property (@(posedge clock) disable iff (reset)
                    phase_ff == PH_SCL_WAIT |-> !scl_drive_ff)
      else $error("waiting on SCL while still pulling it low");

   assert property (@(posedge clock) disable iff (reset)
                    step && finish |=> phase_ff == PH_IDLE)
      else $error("engine not idle after finishing a byte");

endmodule
`default_nettype wire

[hdl/i2c_master_byte_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master byte engine
// Open-drain I2C master that writes or reads one byte per command.
// ----------------------------------------------------------------------------
// Usage:
//   Each req_ item is one bus tick: the sampled SDA/SCL levels plus an
//   optional byte command (write or read). Every item yields exactly one
//   rsp_ item with the line pull-downs and status after that tick.
//   csr_write_en/csr_write_data set the per-phase delay in ticks; write it
//   only while no transfer is running.
// Pipeline and throughput:
//   An item is registered on acceptance, stepped through the phase
//   sequencer once the result register is free and lands in it. One
//   item per cycle is sustained while rsp_ready stays high; the input and
//   result registers are the stages, the sequencer's logic between them.
// Reset:
//   Synchronous, active high. Both lines are released, the engine is idle,
//   the delay register returns to one tick and both channels are empty.
// Stall:
//   While rsp_ready is low the result is held; the input register still
//   takes one more item, then req_ready drops until the result moves.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
   import i2cm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [1:0]          req_cmd,
   input  wire logic [7:0]          req_write_byte,
   input  wire logic                req_send_nack,
   input  wire logic                req_sda_level,
   input  wire logic                req_scl_level,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic                rsp_scl_pull_low,
   output      logic                rsp_sda_pull_low,
   output      logic                rsp_busy_res,
   output      logic                rsp_done_res,
   output      logic [7:0]          rsp_read_byte,
   output      logic                rsp_ack_missing,
   input  wire logic                csr_write_en,
   input  wire logic [CSR_BITS-1:0] csr_write_data
);

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       advance;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign req_item.cmd        = req_cmd;
   assign req_item.write_byte = req_write_byte;
   assign req_item.send_nack  = req_send_nack;
   assign req_item.sda_level  = req_sda_level;
   assign req_item.scl_level  = req_scl_level;

   // step the engine when an item is held and the result slot is free
   assign advance      = item_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   i2cm_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   i2cm_core u_core (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .step           (advance),
      .item           (item),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_pull_low = rsp_ff.scl_pull_low;
   assign rsp_sda_pull_low = rsp_ff.sda_pull_low;
   assign rsp_busy_res     = rsp_ff.busy_res;
   assign rsp_done_res     = rsp_ff.done_res;
   assign rsp_read_byte    = rsp_ff.read_byte;
   assign rsp_ack_missing  = rsp_ff.ack_missing;

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff |-> !(rsp_ff.done_res && rsp_ff.busy_res))
      else $error("result reports done and busy together");

   assert property (@(posedge clock) disable iff (reset)
                    item_valid && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input taken with both stages full and output stalled");

endmodule
`default_nettype wire
